// File: rtl/core/isis_pkg.sv
// Package: types, constants and commands for the interval split index sampler.
package isis_pkg;
	localparam int MAX_INTERVALS = 512;
	localparam int INDEX_BITS    = 16;
	localparam int ADDR_W        = $clog2(MAX_INTERVALS);
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int SPAN_W        = INDEX_BITS + 1;

	localparam logic [0:0] REG_RANGE_LOW  = 1'b0;
	localparam logic [0:0] REG_RANGE_HIGH = 1'b1;
	localparam logic       MODE_RESTART   = 1'b0;
	localparam logic       MODE_DRAW      = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] piece_random;
		logic [31:0] offset_random;
	} in_item_t;

	typedef struct packed {
		logic signed [16:0] drawn_index;
		logic               exhausted;
		logic               restart_ok;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESTART,
		ST_PDIV,
		ST_RD,
		ST_RDWAIT,
		ST_ODIV,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_APP_HI,
		ST_APP_LO,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_item;
		logic do_restart;
		logic pdiv_start;
		logic latch_iv;
		logic odiv_start;
		logic shift_rd;
		logic shift_wr;
		logic app_hi;
		logic app_lo;
		logic result_empty;
		logic result_pick;
		logic result_restart;
	} ctrl_t;

	typedef struct packed {
		logic count_zero;
		logic div_done;
		logic shift_more;
		logic shift_next;
		logic need_hi;
		logic need_lo;
		logic out_busy;
	} stat_t;
endpackage

// File: rtl/core/isis_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
module isis_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/core/isis_div.sv
// Restoring radix-2 remainder unit: 32-bit dividend, up to 32-bit divisor.
module isis_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);
	logic [32:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted   = {rem_q[31:0], dvd_q[31]};
	assign trial     = shifted - {1'b0, dvs_q};
	assign remainder = rem_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			rem_q <= trial[32] ? shifted : trial;
		end
	end
endmodule

// File: rtl/core/isis_ctrl.sv
// Controller state machine sequencing restart and draw items.
module isis_ctrl
	import isis_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  logic   in_mode,
	input  stat_t  stat,
	output logic   in_stall,
	output ctrl_t  ctrl
);
	state_t state_q, state_d;
	logic   mode_q;

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= MODE_RESTART;
		end else begin
			state_q <= state_d;
			if (in_valid && !in_stall) begin
				mode_q <= in_mode;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) begin
					state_d = (in_mode == MODE_RESTART) ? ST_RESTART : ST_PDIV;
				end
			end
			ST_RESTART: state_d = ST_DONE;
			ST_PDIV: begin
				if (stat.count_zero) begin
					state_d = ST_DONE;
				end else if (stat.div_done) begin
					state_d = ST_RD;
				end
			end
			ST_RD:     state_d = ST_RDWAIT;
			ST_RDWAIT: state_d = ST_ODIV;
			ST_ODIV: begin
				if (stat.div_done) begin
					state_d = stat.shift_more ? ST_SHIFT_RD : ST_APP_HI;
				end
			end
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = stat.shift_next ? ST_SHIFT_RD : ST_APP_HI;
			ST_APP_HI:   state_d = ST_APP_LO;
			ST_APP_LO:   state_d = ST_DONE;
			ST_DONE:     state_d = stat.out_busy ? ST_DONE : ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.load_item = in_valid && !in_stall;
			ST_RESTART: ctrl.do_restart = 1'b1;
			ST_PDIV: ctrl.pdiv_start = 1'b0;
			ST_RDWAIT: begin
				ctrl.latch_iv = 1'b1;
			end
			ST_ODIV: ctrl.odiv_start = 1'b0;
			ST_SHIFT_RD: ctrl.shift_rd = 1'b1;
			ST_SHIFT_WR: ctrl.shift_wr = 1'b1;
			ST_APP_HI: ctrl.app_hi = stat.need_hi;
			ST_APP_LO: ctrl.app_lo = stat.need_lo;
			ST_DONE: begin
				ctrl.result_restart = (mode_q == MODE_RESTART) && !stat.out_busy;
				ctrl.result_empty   = (mode_q == MODE_DRAW) && stat.count_zero
					&& !stat.out_busy;
				ctrl.result_pick    = (mode_q == MODE_DRAW) && !stat.count_zero
					&& !stat.out_busy;
			end
			default: ctrl = '0;
		endcase
		// divider starts: on entry into each division state
		if (state_q == ST_IDLE && in_valid && !in_stall && in_mode == MODE_DRAW) begin
			ctrl.pdiv_start = 1'b1;
		end
		if (state_q == ST_RDWAIT) begin
			ctrl.odiv_start = 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("item accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESTART) |=> (state_q == ST_DONE))
		else $error("restart did not finish");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |=> (state_q == ST_RDWAIT))
		else $error("read wait skipped");
endmodule

// File: rtl/core/isis_dp.sv
// Datapath: interval store, count, limits, one shared divider and result register.
module isis_dp
	import isis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  ctrl_t     ctrl,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [15:0] cfg_data,
	input  logic      out_stall,
	output stat_t     stat,
	output logic      out_valid,
	output out_item_t out_data
);
	logic signed [INDEX_BITS-1:0] range_low_q, range_high_q, cfg_v;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] piece_q, ptr_q;
	logic [31:0] orand_q;
	logic signed [INDEX_BITS-1:0] lo_q, hi_q, pick_q;
	logic [31:0] div_dvd, div_dvs, div_rem;
	logic        div_start, div_done;
	logic        we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [2*INDEX_BITS-1:0] wdata, rdata;
	logic [SPAN_W-1:0] span;
	logic signed [16:0] cfg_s;

	// saturate incoming limit to INDEX_BITS signed
	always_comb begin
		cfg_s = 17'(signed'(cfg_data));
		if (cfg_s > 17'sd0 + ((17'sd1 <<< (INDEX_BITS - 1)) - 17'sd1)) begin
			cfg_v = {1'b0, {(INDEX_BITS-1){1'b1}}};
		end else if (cfg_s < -(17'sd1 <<< (INDEX_BITS - 1))) begin
			cfg_v = {1'b1, {(INDEX_BITS-1){1'b0}}};
		end else begin
			cfg_v = INDEX_BITS'(cfg_s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= INDEX_BITS'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_RANGE_LOW && range_high_q > cfg_v) begin
				range_low_q <= cfg_v;
			end else if (cfg_index == REG_RANGE_HIGH && range_low_q < cfg_v) begin
				range_high_q <= cfg_v;
			end
		end
	end

	// span of the interval just read; the offset division starts on the read data
	assign span      = SPAN_W'($signed(rdata[INDEX_BITS-1:0]))
		- SPAN_W'($signed(rdata[2*INDEX_BITS-1:INDEX_BITS]));
	assign div_start = ctrl.pdiv_start | ctrl.odiv_start;
	assign div_dvd   = ctrl.pdiv_start ? in_data.piece_random : orand_q;
	assign div_dvs   = ctrl.pdiv_start ? 32'(count_q) : 32'(span) + 32'd1;

	isis_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .remainder(div_rem)
	);

	// store write and read addressing; a remainder that finds the list full is dropped
	always_comb begin
		we    = ctrl.do_restart | ctrl.shift_wr
			| ((ctrl.app_hi | ctrl.app_lo) && count_q < CNT_W'(MAX_INTERVALS));
		waddr = ptr_q;
		wdata = rdata;
		raddr = ptr_q + ADDR_W'(1);
		if (ctrl.do_restart) begin
			waddr = '0;
			wdata = {range_low_q, range_high_q};
		end else if (ctrl.app_hi) begin
			waddr = ADDR_W'(count_q);
			wdata = {pick_q + INDEX_BITS'(1), hi_q};
		end else if (ctrl.app_lo) begin
			waddr = ADDR_W'(count_q);
			wdata = {lo_q, pick_q - INDEX_BITS'(1)};
		end
		if (!(ctrl.shift_rd | ctrl.shift_wr)) begin
			raddr = piece_q;
		end
	end

	isis_ram #(.WIDTH(2*INDEX_BITS), .DEPTH(MAX_INTERVALS)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (ctrl.do_restart) begin
				count_q <= CNT_W'(1);
			end
			if (ctrl.odiv_start) begin
				count_q <= count_q - CNT_W'(1);
			end
			if ((ctrl.app_hi || ctrl.app_lo) && count_q < CNT_W'(MAX_INTERVALS)) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (ctrl.result_empty | ctrl.result_pick | ctrl.result_restart) begin
				out_valid <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			orand_q <= in_data.offset_random;
		end
		if (ctrl.latch_iv) begin
			lo_q <= rdata[2*INDEX_BITS-1:INDEX_BITS];
			hi_q <= rdata[INDEX_BITS-1:0];
			ptr_q <= piece_q;
		end
		if (ctrl.shift_wr) begin
			ptr_q <= ptr_q + ADDR_W'(1);
		end
		if (ctrl.result_empty) begin
			out_data <= '{drawn_index: 17'(range_low_q) - 17'sd1,
				exhausted: 1'b1, restart_ok: 1'b0};
		end else if (ctrl.result_pick) begin
			out_data <= '{drawn_index: 17'(pick_q), exhausted: 1'b0, restart_ok: 1'b0};
		end else if (ctrl.result_restart) begin
			out_data <= '{drawn_index: '0, exhausted: 1'b0, restart_ok: 1'b1};
		end
	end

	// piece and pick capture, told apart by which phase is active
	logic phase_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (ctrl.pdiv_start) begin
			phase_q <= 1'b0;
		end else if (ctrl.odiv_start) begin
			phase_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (div_done && !phase_q) begin
			piece_q <= ADDR_W'(div_rem);
		end
		if (div_done && phase_q) begin
			pick_q <= lo_q + INDEX_BITS'(div_rem);
		end
	end

	always_comb begin
		stat.count_zero = (count_q == '0) && !phase_q;
		stat.div_done   = div_done;
		stat.shift_more = (CNT_W'(ptr_q) < count_q) && phase_q;
		stat.shift_next = (CNT_W'(ptr_q) + CNT_W'(1) < count_q) && phase_q;
		stat.need_hi    = pick_q < hi_q;
		stat.need_lo    = pick_q > lo_q;
		stat.out_busy   = out_valid;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_INTERVALS))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.do_restart |=> (count_q == CNT_W'(1)))
		else $error("restart count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("result changed under stall");
endmodule

// File: rtl/core/interval_split_index_sampler.sv
// Top level of the interval split index sampler.
//
// Hands out indices of [range_low, range_high] in random order without repeats.
// Input channel: in_valid/in_stall carry mode, piece_random, offset_random.
// mode 0 reloads the free list with the whole range; mode 1 draws one index.
// Output channel: out_valid/out_stall carry drawn_index, exhausted, restart_ok.
// Exactly one result per item; a draw on an empty list returns range_low - 1
// with exhausted set.
// A draw from a non-empty list runs two 32-step remainder divisions, then
// moves each list entry behind the chosen interval up one place to close it up.
// The list store is a single RAM (one write, one registered read) and the
// compaction loop over it sets the draw time.
// One item at a time: in_stall stays high while an item is being worked on.
// A new item may be taken while the previous result still waits; its own
// result is held back until the result register is free.
// When the receiver stalls, the result holds unchanged. Reset clears the list
// count (empty list) and sets the limits to 0 and 1. Limit writes go through
// cfg_we/cfg_index/cfg_data while idle: a user rule the block does not enforce.
module interval_split_index_sampler
	import isis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	ctrl_t ctrl;
	stat_t stat;

	isis_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_mode(in_data.mode),
		.stat(stat), .in_stall(in_stall), .ctrl(ctrl)
	);

	isis_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .ctrl(ctrl),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_stall(out_stall), .stat(stat), .out_valid(out_valid), .out_data(out_data)
	);
endmodule

// File: tb/testbench.sv
// Testbench for the interval split index sampler: predicts every result and checks it.
`timescale 1ns / 1ps

module testbench;
	import isis_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 1200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// Predictor state: limits and the ordered free-interval list
	int          lim_low;
	int          lim_high;
	int          iv_low[$];
	int          iv_high[$];
	out_item_t   pending_results[$];

	int          fail_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          quiet_cycles;

	interval_split_index_sampler u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Register write as the block sees it: sign taken at 16 bits, then the check
	// against the other limit. With INDEX_BITS of 16 saturation never bites.
	function automatic void predict_limit_write(logic idx, logic [15:0] raw);
		int v;
		v = $signed(raw);
		if (v > (1 <<< (INDEX_BITS - 1)) - 1) v = (1 <<< (INDEX_BITS - 1)) - 1;
		if (v < -(1 <<< (INDEX_BITS - 1))) v = -(1 <<< (INDEX_BITS - 1));
		if (idx == REG_RANGE_LOW) begin
			if (lim_high > v) lim_low = v;
		end else begin
			if (lim_low < v) lim_high = v;
		end
	endfunction

	function automatic void append_free(int lo, int hi);
		if (iv_low.size() < MAX_INTERVALS) begin
			iv_low  = {iv_low, lo};
			iv_high = {iv_high, hi};
		end
	endfunction

	// Next drawn index (or restart acknowledgement) for one item
	function automatic out_item_t predict_draw(in_item_t it);
		out_item_t   r;
		int          piece;
		int          lo;
		int          hi;
		int          pick;
		logic [31:0] span;
		r = '0;
		if (it.mode == MODE_RESTART) begin
			iv_low.delete();
			iv_high.delete();
			append_free(lim_low, lim_high);
			r.restart_ok = 1'b1;
		end else if (iv_low.size() == 0) begin
			r.drawn_index = 17'(lim_low - 1);
			r.exhausted   = 1'b1;
		end else begin
			piece = int'(it.piece_random % 32'(iv_low.size()));
			lo    = iv_low[piece];
			hi    = iv_high[piece];
			span  = 32'(hi - lo);
			pick  = lo + int'(it.offset_random % (span + 32'd1));
			iv_low.delete(piece);
			iv_high.delete(piece);
			if (pick < hi) append_free(pick + 1, hi);
			if (pick > lo) append_free(lo, pick - 1);
			r.drawn_index = 17'(pick);
		end
		return r;
	endfunction

	// Receiver: random stall, compare each transfer with the oldest prediction
	always @(negedge clk) begin
		if (arst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				fail_count++;
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (out_data.drawn_index !== want.drawn_index) begin
					$display("%0t: drawn_index expected %0d actual %0d", $time,
						want.drawn_index, out_data.drawn_index);
					fail_count++;
				end
				if (out_data.exhausted !== want.exhausted) begin
					$display("%0t: exhausted expected %b actual %b", $time,
						want.exhausted, out_data.exhausted);
					fail_count++;
				end
				if (out_data.restart_ok !== want.restart_ok) begin
					$display("%0t: restart_ok expected %b actual %b", $time,
						want.restart_ok, out_data.restart_ok);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("== FAIL ==");
			$finish;
		end
	end

	// One item: optional gap, then hold valid until the transfer. Valid stays
	// high after the transfer until the next item, a gap or a drain drops it.
	task automatic send_item(logic mode, logic [31:0] prand, logic [31:0] orand);
		in_item_t it;
		it.mode          = mode;
		it.piece_random  = prand;
		it.offset_random = orand;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results = {pending_results, predict_draw(it)};
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(logic idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		predict_limit_write(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_range(int lo, int hi);
		// order the writes so neither is rejected by the old limits
		if (lo >= lim_high) begin
			write_limit(REG_RANGE_HIGH, 16'(hi));
			write_limit(REG_RANGE_LOW, 16'(lo));
		end else begin
			write_limit(REG_RANGE_LOW, 16'(lo));
			write_limit(REG_RANGE_HIGH, 16'(hi));
		end
	endtask

	// Directed: empty list, rejected writes, extremes, full exhaustion
	task automatic test_directed();
		send_item(MODE_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // draw before restart
		send_item(MODE_RESTART, 32'h0, 32'h0);
		send_item(MODE_DRAW, 32'h0, 32'h0);
		send_item(MODE_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(MODE_DRAW, 32'h0, 32'h0);                   // range used up
		wait_drained();
		write_limit(REG_RANGE_LOW, 16'd1);                     // rejected: not below high
		write_limit(REG_RANGE_HIGH, 16'h8000);                 // rejected: not above low
		write_limit(REG_RANGE_LOW, 16'h8000);
		write_limit(REG_RANGE_HIGH, 16'h7FFF);
		send_item(MODE_RESTART, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(MODE_DRAW, 32'h0, 32'hFFFF_FFFF);
		send_item(MODE_DRAW, 32'hFFFF_FFFF, 32'h0);
		send_item(MODE_DRAW, 32'h5555_5555, 32'hAAAA_AAAA);
		send_item(MODE_DRAW, 32'hAAAA_AAAA, 32'h5555_5555);
		wait_drained();
		set_range(-3, 2);
		send_item(MODE_RESTART, 32'h0, 32'h0);
		repeat (7) send_item(MODE_DRAW, $urandom, $urandom);  // six picks then exhausted
		wait_drained();
	endtask

	// Random phase: a restart now and then, mostly draws over a chosen range
	task automatic test_random_draws(int count, int lo, int hi);
		wait_drained();
		set_range(lo, hi);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 4)
				send_item(MODE_RESTART, $urandom, $urandom);
			else
				send_item(MODE_DRAW, $urandom, $urandom);
			if (i == count / 2) wait_drained();   // sender holds off until all results are in
		end
	endtask

	// Wide range: list fills up to MAX_INTERVALS entries, then remainders are dropped
	task automatic test_list_full();
		wait_drained();
		set_range(-32768, 32767);
		send_item(MODE_RESTART, 32'h0, 32'h0);
		for (int i = 0; i < 600; i++)
			send_item(MODE_DRAW, $urandom, $urandom);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		out_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_RANGE_LOW;
		cfg_data      = '0;
		fail_count    = 0;
		quiet_cycles  = 0;
		lim_low       = 0;
		lim_high      = 1;
		send_idle_pct = 18;
		recv_idle_pct = 59;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_draws(150, -8, 12);
		send_idle_pct = 59;
		recv_idle_pct = 18;
		test_random_draws(150, 32760, 32767);
		test_list_full();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_draws(150, -32768, -32700);
		wait_drained();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// File: files.f
rtl/core/isis_pkg.sv
rtl/core/isis_ram.sv
rtl/core/isis_div.sv
rtl/core/isis_ctrl.sv
rtl/core/isis_dp.sv
rtl/core/interval_split_index_sampler.sv
tb/testbench.sv
